// File: src/stt_pkg.sv
// Shared types, codes and constants of the source text tokenizer.
`default_nettype none

package stt_pkg;

  // Parameter defaults
  localparam int unsigned POSITION_BITS_DEF    = 16;
  localparam int unsigned MAX_VALUE_LENGTH_DEF = 255;

  // Pair queue between lexer and output side
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [3:0] {
    TK_FUNC   = 4'd0,
    TK_IDENT  = 4'd1,
    TK_LPAREN = 4'd2,
    TK_RPAREN = 4'd3,
    TK_LBRACE = 4'd4,
    TK_RBRACE = 4'd5,
    TK_STRING = 4'd6,
    TK_NUMBER = 4'd7,
    TK_SEMI   = 4'd8,
    TK_TYPE   = 4'd9,
    TK_END    = 4'd10
  } tok_type_e;

  typedef enum logic [1:0] {
    CAUSE_ZERO  = 2'd0,
    CAUSE_STRAY = 2'd1,
    CAUSE_SLASH = 2'd2
  } cause_e;

  // Character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // Keywords as leading bytes, first byte lowest
  localparam logic [31:0] KW_FN   = 32'h0000_6E66;
  localparam logic [31:0] KW_FUNC = 32'h636E_7566;
  localparam logic [31:0] KW_INT  = 32'h0074_6E69;

  typedef struct packed {
    tok_type_e   tok_type;
    logic [15:0] start;
    logic [7:0]  len;
    logic        too_long;
    cause_e      cause;
  } tok_t;

  // Results of one byte: one token, or two when two is set
  typedef struct packed {
    logic two;
    tok_t tok0;
    tok_t tok1;
  } pair_t;

  function automatic tok_t make_tok(tok_type_e t, logic [15:0] s, logic [7:0] l,
                                    logic f, cause_e c);
    tok_t r;
    r.tok_type = t;
    r.start    = s;
    r.len      = l;
    r.too_long = f;
    r.cause    = c;
    return r;
  endfunction

  function automatic logic is_letter(logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

endpackage

`default_nettype wire

// File: src/stt_front.sv
// Lexer front: per-byte mode update, emits the token pair caused by a byte.
`default_nettype none

module stt_front #(
  parameter int unsigned POSITION_BITS    = stt_pkg::POSITION_BITS_DEF,
  parameter int unsigned MAX_VALUE_LENGTH = stt_pkg::MAX_VALUE_LENGTH_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           accept_i,
  input  wire logic [7:0]     char_i,
  input  wire logic           first_i,
  output stt_pkg::pair_t      pair_o,
  output logic                push_o
);

  localparam int unsigned LEN_BITS = $clog2(MAX_VALUE_LENGTH + 1);
  localparam logic [LEN_BITS-1:0] LEN_MAX = LEN_BITS'(MAX_VALUE_LENGTH);

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_IDENT   = 3'd1,
    MODE_NUMBER  = 3'd2,
    MODE_STRING  = 3'd3,
    MODE_ESCAPE  = 3'd4,
    MODE_SLASH   = 3'd5,
    MODE_COMMENT = 3'd6,
    MODE_DONE    = 3'd7
  } mode_e;

  mode_e                    mode_q, mode_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [POSITION_BITS-1:0] start_q, start_d;
  logic [LEN_BITS-1:0]      len_q, len_d;
  logic                     ovf_q, ovf_d;
  logic [31:0]              lead_q, lead_d;

  // Effective state after an optional restart
  mode_e                    m;
  logic [POSITION_BITS-1:0] p, ts;
  logic [LEN_BITS-1:0]      ln, ln_grow;
  logic                     ov, ov_grow;
  logic [31:0]              ld;

  // Idle path: lexing the byte from a clean state
  logic                     idle_emit, idle_begin, use_idle;
  stt_pkg::tok_t            idle_tok, tok_a;
  mode_e                    idle_mode;
  logic [POSITION_BITS-1:0] idle_start;
  logic [LEN_BITS-1:0]      idle_len;
  logic [31:0]              idle_lead;
  logic                     tok_a_en;
  stt_pkg::tok_type_e       id_type;

  always_comb begin
    if (first_i) begin
      m  = MODE_IDLE;
      p  = '0;
      ts = '0;
      ln = '0;
      ov = 1'b0;
      ld = '0;
    end else begin
      m  = mode_q;
      p  = pos_q;
      ts = start_q;
      ln = len_q;
      ov = ovf_q;
      ld = lead_q;
    end

    // Saturating length growth
    if (ln >= LEN_MAX) begin
      ln_grow = ln;
      ov_grow = 1'b1;
    end else begin
      ln_grow = ln + LEN_BITS'(1);
      ov_grow = ov;
    end

    // Keyword match on a finished identifier
    id_type = stt_pkg::TK_IDENT;
    if (!ov) begin
      if (ln == LEN_BITS'(2) && ld == stt_pkg::KW_FN)
        id_type = stt_pkg::TK_FUNC;
      else if (ln == LEN_BITS'(4) && ld == stt_pkg::KW_FUNC)
        id_type = stt_pkg::TK_FUNC;
      else if (ln == LEN_BITS'(3) && ld == stt_pkg::KW_INT)
        id_type = stt_pkg::TK_TYPE;
    end

    idle_emit  = 1'b0;
    idle_begin = 1'b0;
    idle_mode  = MODE_IDLE;
    idle_start = p;
    idle_len   = '0;
    idle_lead  = '0;
    idle_tok   = stt_pkg::make_tok(stt_pkg::TK_END, 16'(p), 8'd0, 1'b0,
                                   stt_pkg::CAUSE_ZERO);
    priority if (char_i == stt_pkg::CH_SPACE || char_i == stt_pkg::CH_TAB ||
                 char_i == stt_pkg::CH_NL) begin
      idle_emit = 1'b0;
    end else if (char_i == stt_pkg::CH_LPAREN) begin
      idle_emit = 1'b1;
      idle_tok  = stt_pkg::make_tok(stt_pkg::TK_LPAREN, 16'(p), 8'd1, 1'b0,
                                    stt_pkg::CAUSE_ZERO);
    end else if (char_i == stt_pkg::CH_RPAREN) begin
      idle_emit = 1'b1;
      idle_tok  = stt_pkg::make_tok(stt_pkg::TK_RPAREN, 16'(p), 8'd1, 1'b0,
                                    stt_pkg::CAUSE_ZERO);
    end else if (char_i == stt_pkg::CH_LBRACE) begin
      idle_emit = 1'b1;
      idle_tok  = stt_pkg::make_tok(stt_pkg::TK_LBRACE, 16'(p), 8'd1, 1'b0,
                                    stt_pkg::CAUSE_ZERO);
    end else if (char_i == stt_pkg::CH_RBRACE) begin
      idle_emit = 1'b1;
      idle_tok  = stt_pkg::make_tok(stt_pkg::TK_RBRACE, 16'(p), 8'd1, 1'b0,
                                    stt_pkg::CAUSE_ZERO);
    end else if (char_i == stt_pkg::CH_SEMI) begin
      idle_emit = 1'b1;
      idle_tok  = stt_pkg::make_tok(stt_pkg::TK_SEMI, 16'(p), 8'd1, 1'b0,
                                    stt_pkg::CAUSE_ZERO);
    end else if (char_i == stt_pkg::CH_NUL) begin
      idle_emit = 1'b1;
      idle_mode = MODE_DONE;
    end else if (char_i == stt_pkg::CH_QUOTE) begin
      idle_begin = 1'b1;
      idle_start = p + POSITION_BITS'(1);
      idle_mode  = MODE_STRING;
    end else if (char_i == stt_pkg::CH_SLASH) begin
      idle_begin = 1'b1;
      idle_mode  = MODE_SLASH;
    end else if (stt_pkg::is_letter(char_i)) begin
      idle_begin = 1'b1;
      idle_len   = LEN_BITS'(1);
      idle_lead  = 32'(char_i);
      idle_mode  = MODE_IDENT;
    end else if (stt_pkg::is_digit(char_i)) begin
      idle_begin = 1'b1;
      idle_len   = LEN_BITS'(1);
      idle_mode  = MODE_NUMBER;
    end else begin
      idle_emit = 1'b1;
      idle_mode = MODE_DONE;
      idle_tok  = stt_pkg::make_tok(stt_pkg::TK_END, 16'(p), 8'd0, 1'b0,
                                    stt_pkg::CAUSE_STRAY);
    end

    // Mode dispatch
    mode_d   = m;
    start_d  = ts;
    len_d    = ln;
    ovf_d    = ov;
    lead_d   = ld;
    use_idle = 1'b0;
    tok_a_en = 1'b0;
    tok_a    = stt_pkg::make_tok(stt_pkg::TK_STRING, 16'(ts), 8'(ln), ov,
                                 stt_pkg::CAUSE_ZERO);
    unique case (m)
      MODE_IDENT: begin
        if (stt_pkg::is_letter(char_i) || stt_pkg::is_digit(char_i) ||
            char_i == stt_pkg::CH_UNDER) begin
          if (ln < LEN_BITS'(4))
            lead_d = ld | (32'(char_i) << {ln[1:0], 3'b000});
          len_d = ln_grow;
          ovf_d = ov_grow;
        end else begin
          tok_a_en = 1'b1;
          tok_a    = stt_pkg::make_tok(id_type, 16'(ts), 8'(ln), ov, stt_pkg::CAUSE_ZERO);
          use_idle = 1'b1;
        end
      end
      MODE_NUMBER: begin
        if (stt_pkg::is_digit(char_i)) begin
          len_d = ln_grow;
          ovf_d = ov_grow;
        end else begin
          tok_a_en = 1'b1;
          tok_a    = stt_pkg::make_tok(stt_pkg::TK_NUMBER, 16'(ts), 8'(ln), ov,
                                       stt_pkg::CAUSE_ZERO);
          use_idle = 1'b1;
        end
      end
      MODE_STRING, MODE_ESCAPE: begin
        priority if (char_i == stt_pkg::CH_NUL) begin
          // Flush the open string, then stop on the zero byte
          tok_a_en  = 1'b1;
          use_idle  = 1'b1;
        end else if (m == MODE_ESCAPE) begin
          len_d  = ln_grow;
          ovf_d  = ov_grow;
          mode_d = MODE_STRING;
        end else if (char_i == stt_pkg::CH_QUOTE) begin
          tok_a_en = 1'b1;
          mode_d   = MODE_IDLE;
        end else begin
          len_d = ln_grow;
          ovf_d = ov_grow;
          if (char_i == stt_pkg::CH_BSLASH)
            mode_d = MODE_ESCAPE;
        end
      end
      MODE_SLASH: begin
        if (char_i == stt_pkg::CH_SLASH) begin
          mode_d = MODE_COMMENT;
        end else begin
          tok_a_en = 1'b1;
          tok_a    = stt_pkg::make_tok(stt_pkg::TK_END, 16'(ts), 8'd0, 1'b0,
                                       stt_pkg::CAUSE_SLASH);
          mode_d   = MODE_DONE;
        end
      end
      MODE_COMMENT: begin
        if (char_i == stt_pkg::CH_NUL)
          use_idle = 1'b1;
        else if (char_i == stt_pkg::CH_NL)
          mode_d = MODE_IDLE;
      end
      MODE_IDLE: begin
        use_idle = 1'b1;
      end
      MODE_DONE: begin
        use_idle = 1'b0;
      end
      default: begin
        use_idle = 1'b0;
      end
    endcase

    if (use_idle) begin
      mode_d = idle_mode;
      if (idle_begin) begin
        start_d = idle_start;
        len_d   = idle_len;
        ovf_d   = 1'b0;
        lead_d  = idle_lead;
      end
    end

    pos_d = p + POSITION_BITS'(1);

    pair_o.two  = tok_a_en && use_idle && idle_emit;
    pair_o.tok0 = tok_a_en ? tok_a : idle_tok;
    pair_o.tok1 = idle_tok;
    push_o      = accept_i && (m != MODE_DONE) && (tok_a_en || (use_idle && idle_emit));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      pos_q   <= '0;
      start_q <= '0;
      len_q   <= '0;
      ovf_q   <= 1'b0;
      lead_q  <= '0;
    end else if (accept_i && (m != MODE_DONE)) begin
      mode_q  <= mode_d;
      pos_q   <= pos_d;
      start_q <= start_d;
      len_q   <= len_d;
      ovf_q   <= ovf_d;
      lead_q  <= lead_d;
    end else if (accept_i && first_i) begin
      mode_q <= MODE_IDLE;
    end
  end

endmodule

`default_nettype wire

// File: src/stt_queue.sv
// Short queue of token pairs between lexer front and output side.
`default_nettype none

module stt_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  stt_pkg::pair_t      pair_i,
  input  wire logic           pop_i,
  output stt_pkg::pair_t      head_o,
  output logic                empty_o,
  output logic                full_o
);

  localparam int unsigned PTR_BITS = $clog2(stt_pkg::QUEUE_DEPTH);
  localparam int unsigned CNT_BITS = $clog2(stt_pkg::QUEUE_DEPTH + 1);

  stt_pkg::pair_t      mem_q [stt_pkg::QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_q, rd_q;
  logic [CNT_BITS-1:0] cnt_q;
  logic                do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CNT_BITS'(stt_pkg::QUEUE_DEPTH));
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push)
      mem_q[wr_q] <= pair_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push)
        wr_q <= wr_q + PTR_BITS'(1);
      if (do_pop)
        rd_q <= rd_q + PTR_BITS'(1);
      if (do_push && !do_pop)
        cnt_q <= cnt_q + CNT_BITS'(1);
      else if (do_pop && !do_push)
        cnt_q <= cnt_q - CNT_BITS'(1);
    end
  end

endmodule

`default_nettype wire

// File: src/stt_back.sv
// Output side: splits queued pairs into single tokens in an output register.
`default_nettype none

module stt_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  stt_pkg::pair_t      head_i,
  input  wire logic           empty_i,
  output logic                pop_o,
  input  wire logic           ready_i,
  output logic                valid_o,
  output stt_pkg::tok_t       tok_o,
  output logic                last_o
);

  logic          half_q;
  logic          valid_q, last_q;
  stt_pkg::tok_t tok_q;
  logic          load;

  // Load when the output register is free or drains this cycle
  assign load  = !empty_i && (!valid_q || ready_i);
  assign pop_o = load && (half_q || !head_i.two);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      half_q  <= 1'b0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        half_q  <= head_i.two && !half_q;
      end else if (ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      tok_q  <= half_q ? head_i.tok1 : head_i.tok0;
      last_q <= half_q || !head_i.two;
    end
  end

  assign valid_o = valid_q;
  assign tok_o   = tok_q;
  assign last_o  = last_q;

endmodule

`default_nettype wire

// File: src/source_text_tokenizer.sv
// Top level of the source text tokenizer: lexer front, pair queue, output side.
//
//  Channel | Dir | tdata                                   | tuser | tlast
//  s_axis  | in  | [7:0] character                         | first | -
//  m_axis  | out | [3:0] type [19:4] start [27:20] length  | -     | last
//          |     | [28] too_long [30:29] stop_cause [31] 0 |       |
//
//  Cycles: one byte is accepted per cycle while the queue is not full; the
//  front updates the lexing mode in the same cycle and writes its result pair
//  into a four-entry queue. The output side drains one token per cycle unless
//  stalled, so a byte that gives two tokens is sent as two transfers; the
//  queue absorbs such bursts. Tokens pass the queue, then the output register.
//  Reset clears the lexer to idle at position zero and empties the queue.
//  s_axis_tready_o drops only while the queue is full; a stalled output holds.
`default_nettype none

module source_text_tokenizer #(
  parameter int unsigned POSITION_BITS    = stt_pkg::POSITION_BITS_DEF,
  parameter int unsigned MAX_VALUE_LENGTH = stt_pkg::MAX_VALUE_LENGTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] character
  input  wire logic        s_axis_tuser_i,   // [0] first
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [31:0]      m_axis_tdata_o,   // type, start, length, too_long, cause, pad
  output logic             m_axis_tlast_o
);

  stt_pkg::pair_t front_pair, head_pair;
  stt_pkg::tok_t  out_tok;
  logic           push, pop, q_empty, q_full, accept;

  // Take a byte whenever the queue has room for its pair
  assign s_axis_tready_o = !q_full;
  assign accept          = s_axis_tvalid_i && !q_full;

  stt_front #(
    .POSITION_BITS    (POSITION_BITS),
    .MAX_VALUE_LENGTH (MAX_VALUE_LENGTH)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .char_i   (s_axis_tdata_i),
    .first_i  (s_axis_tuser_i),
    .pair_o   (front_pair),
    .push_o   (push)
  );

  stt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pair_i  (front_pair),
    .pop_i   (pop),
    .head_o  (head_pair),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  stt_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head_pair),
    .empty_i (q_empty),
    .pop_o   (pop),
    .ready_i (m_axis_tready_i),
    .valid_o (m_axis_tvalid_o),
    .tok_o   (out_tok),
    .last_o  (m_axis_tlast_o)
  );

  // Pack the token fields, lowest field first
  assign m_axis_tdata_o = {1'b0, out_tok.cause, out_tok.too_long, out_tok.len,
                           out_tok.start, out_tok.tok_type};

endmodule

`default_nettype wire

// File: src/stt_checker.sv
// Port-level checks of the tokenizer output and their binding to the top level.
`default_nettype none

module stt_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [31:0] m_axis_tdata_o,
  input wire logic        m_axis_tlast_o
);

  logic [3:0] otype;
  logic       is_punct;

  assign otype    = m_axis_tdata_o[3:0];
  assign is_punct = (otype == stt_pkg::TK_LPAREN) || (otype == stt_pkg::TK_RPAREN) ||
                    (otype == stt_pkg::TK_LBRACE) || (otype == stt_pkg::TK_RBRACE) ||
                    (otype == stt_pkg::TK_SEMI);

  // Hold a stalled transfer
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("output changed while stalled");

  // End token is empty and always closes its byte
  a_end_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && otype == stt_pkg::TK_END |->
      m_axis_tlast_o && m_axis_tdata_o[27:20] == 8'd0 && !m_axis_tdata_o[28])
    else $error("malformed end token");

  // Stop cause only on end tokens
  a_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && otype != stt_pkg::TK_END |-> m_axis_tdata_o[30:29] == 2'd0)
    else $error("stop cause on a non-end token");

  // Punctuation is one byte and always the final result of its byte
  a_punct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && is_punct |->
      m_axis_tdata_o[27:20] == 8'd1 && !m_axis_tdata_o[28] && m_axis_tlast_o)
    else $error("malformed punctuation token");

endmodule

bind source_text_tokenizer stt_checker u_stt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

`default_nettype wire
